### rtl/core/vapi_pkg.sv
// Shared types and command codes for the vote accumulator core.
package vapi_pkg;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_INC   = 2'd2;
	localparam logic [1:0] CMD_PATCH = 2'd3;

	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOB = 1'b1;

	// Cell coordinates reach 256 at most (a patch one past the last input row).
	localparam int IDX_W = 9;
	localparam int RES_W = 16;

	typedef struct packed {
		logic [1:0]       cmd;
		logic             oob;
		logic [IDX_W-1:0] rlo;
		logic [IDX_W-1:0] rhi;
		logic [IDX_W-1:0] clo;
		logic [IDX_W-1:0] chi;
		logic [15:0]      value;
	} op_t;

	typedef struct packed {
		logic [RES_W-1:0] result;
		logic             status;
	} res_t;

endpackage

### rtl/core/vote_accumulator_patch_increment_core.sv
// An out-of-range request is answered when it is taken from the request queue; write, read
// and increment pass through one RUN step, and a patch increment through one per window cell.
// The core takes a new request only once the last one is finished, since there is one
// read-modify-write per store cell on the single write port; a full result queue also holds it.
// Reset clears the size registers to 256 and starts a clearing pass over the store of
// 2^(ROW_AW+COL_AW) entries (65536 at default sizes), during which full stays high.
module vote_accumulator_patch_increment_core
	import vapi_pkg::*;
#(
	parameter int MAX_ROWS    = 256,
	parameter int MAX_COLS    = 256,
	parameter int COUNT_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       cmd,
	input  logic [7:0]       row,
	input  logic [7:0]       col,
	input  logic [15:0]      value,
	output logic             empty,
	input  logic             pop,
	output logic [RES_W-1:0] result,
	output logic             status,
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [8:0]       cfg_wdata
);

	logic [8:0] num_rows_q, num_cols_q;
	logic       op_valid, op_take, clearing;
	op_t        op_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= 9'd256;
			num_cols_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_NUM_ROWS: num_rows_q <= cfg_wdata;
				REG_NUM_COLS: num_cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	vapi_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.cmd     (cmd),
		.row     (row),
		.col     (col),
		.value   (value),
		.num_rows(num_rows_q),
		.num_cols(num_cols_q),
		.clearing(clearing),
		.op_valid(op_valid),
		.op_head (op_head),
		.op_take (op_take)
	);

	vapi_back #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_valid(op_valid),
		.op_head (op_head),
		.op_take (op_take),
		.clearing(clearing),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.status  (status)
	);

endmodule

### rtl/core/vapi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module vapi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/vapi_front.sv
// Front end: bounds check, patch clipping and a two-entry request queue.
module vapi_front
	import vapi_pkg::*;
#(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  logic [7:0] row,
	input  logic [7:0] col,
	input  logic [15:0] value,
	input  logic [8:0] num_rows,
	input  logic [8:0] num_cols,
	input  logic       clearing,
	output logic       op_valid,
	output op_t        op_head,
	input  logic       op_take
);

	localparam int ROW_LIM = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
	localparam int COL_LIM = (MAX_COLS > 511) ? 511 : MAX_COLS;

	logic [8:0] nr, nc, row9, col9;
	logic       is_patch, accept;
	op_t        op_new;

	op_t        q_mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_comb begin
		nr       = (num_rows > 9'(ROW_LIM)) ? 9'(ROW_LIM) : num_rows;
		nc       = (num_cols > 9'(COL_LIM)) ? 9'(COL_LIM) : num_cols;
		row9     = {1'b0, row};
		col9     = {1'b0, col};
		is_patch = (cmd == CMD_PATCH);
		op_new.cmd   = cmd;
		op_new.value = value;
		op_new.oob   = (row9 >= nr) || (col9 >= nc);
		// Patch edges are clipped to the rows and columns in use.
		op_new.rlo = (is_patch && row9 != 9'd0) ? row9 - 9'd1 : row9;
		op_new.rhi = (is_patch && (row9 + 9'd1) < nr) ? row9 + 9'd1 : row9;
		op_new.clo = (is_patch && col9 != 9'd0) ? col9 - 9'd1 : col9;
		op_new.chi = (is_patch && (col9 + 9'd1) < nc) ? col9 + 9'd1 : col9;
	end

	assign full     = (cnt_q == 2'd2) || clearing;
	assign accept   = push && !full;
	assign op_valid = (cnt_q != 2'd0);
	assign op_head  = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem_q[wp_q] <= op_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				wp_q <= !wp_q;
			end
			if (op_take) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(accept) - 2'(op_take);
		end
	end

endmodule

### rtl/core/vapi_back.sv
// Back end: clearing pass, read-modify-write sequencer over the store, result queue.
module vapi_back
	import vapi_pkg::*;
#(
	parameter int MAX_ROWS    = 256,
	parameter int MAX_COLS    = 256,
	parameter int COUNT_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	input  op_t              op_head,
	output logic             op_take,
	output logic             clearing,
	output logic             empty,
	input  logic             pop,
	output logic [RES_W-1:0] result,
	output logic             status
);

	localparam int ROW_AW = $clog2((MAX_ROWS > 257) ? 257 : MAX_ROWS);
	localparam int COL_AW = $clog2((MAX_COLS > 257) ? 257 : MAX_COLS);
	localparam int AW     = ROW_AW + COL_AW;
	localparam int DEPTH  = 1 << AW;
	localparam int EXT_W  = (COUNT_WIDTH > RES_W) ? COUNT_WIDTH : RES_W;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [1:0]             state_q;
	logic [AW-1:0]          clr_q;
	logic [1:0]             cmd_q;
	logic [15:0]            value_q;
	logic [IDX_W-1:0]       r_q, c_q, rhi_q, clo_q, chi_q;
	logic                   last_s1;
	logic [AW-1:0]          addr_s1;
	logic [COUNT_WIDTH-1:0] best_q;

	logic [IDX_W-1:0]       r_nxt, c_nxt;
	logic                   last_nxt, last_first;
	logic [AW-1:0]          raddr, waddr;
	logic                   we;
	logic [COUNT_WIDTH-1:0] wdata, old, bumped, sat_val, best_new, res_cnt;
	logic [EXT_W-1:0]       val_e, res_e;
	logic                   room;

	res_t                   out_mem_q [2];
	logic                   owp_q, orp_q;
	logic [1:0]             ocnt_q;
	logic                   out_push, out_pop;
	res_t                   out_new;

	vapi_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(old)
	);

	assign clearing = (state_q == ST_CLEAR);
	assign room     = (ocnt_q != 2'd2);
	assign op_take  = (state_q == ST_IDLE) && op_valid && room;

	always_comb begin
		val_e    = EXT_W'(value_q);
		sat_val  = (val_e > EXT_W'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(val_e);
		bumped   = (old == CNT_MAX) ? old : old + COUNT_WIDTH'(1);
		best_new = (old > best_q) ? old : best_q;

		// Walk the clipped window row by row.
		c_nxt    = (c_q == chi_q) ? clo_q : c_q + IDX_W'(1);
		r_nxt    = (c_q == chi_q) ? r_q + IDX_W'(1) : r_q;
		last_nxt = (r_nxt == rhi_q) && (c_nxt == chi_q);
		last_first = (op_head.rlo == op_head.rhi) && (op_head.clo == op_head.chi);

		if (state_q == ST_RUN) begin
			raddr = {r_nxt[ROW_AW-1:0], c_nxt[COL_AW-1:0]};
		end else begin
			raddr = {op_head.rlo[ROW_AW-1:0], op_head.clo[COL_AW-1:0]};
		end

		we    = 1'b0;
		waddr = addr_s1;
		wdata = bumped;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_RUN: begin
				we    = (cmd_q != CMD_READ);
				wdata = (cmd_q == CMD_WRITE) ? sat_val : bumped;
			end
			default: begin
				we = 1'b0;
			end
		endcase

		unique case (cmd_q)
			CMD_WRITE: res_cnt = sat_val;
			CMD_READ:  res_cnt = old;
			CMD_INC:   res_cnt = bumped;
			CMD_PATCH: res_cnt = best_new;
			default:   res_cnt = old;
		endcase
		res_e = EXT_W'(res_cnt);

		out_push = 1'b0;
		out_new  = '{result: '0, status: STATUS_OK};
		if (op_take && op_head.oob) begin
			out_push = 1'b1;
			out_new  = '{result: '0, status: STATUS_OOB};
		end else if (state_q == ST_RUN && last_s1) begin
			out_push = 1'b1;
			out_new.result = (res_e > EXT_W'(16'hFFFF)) ? 16'hFFFF : RES_W'(res_e);
			out_new.status = STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (op_take) begin
			cmd_q   <= op_head.cmd;
			value_q <= op_head.value;
			rhi_q   <= op_head.rhi;
			clo_q   <= op_head.clo;
			chi_q   <= op_head.chi;
		end
		if (state_q == ST_IDLE || (state_q == ST_RUN && !last_s1)) begin
			addr_s1 <= raddr;
		end
		if (op_take) begin
			r_q <= op_head.rlo;
			c_q <= op_head.clo;
		end else if (state_q == ST_RUN && !last_s1) begin
			r_q <= r_nxt;
			c_q <= c_nxt;
		end
		if (op_take) begin
			best_q <= '0;
		end else if (state_q == ST_RUN) begin
			best_q <= best_new;
		end
		if (out_push) begin
			out_mem_q[owp_q] <= out_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			last_s1 <= 1'b0;
			owp_q   <= 1'b0;
			orp_q   <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (op_take && !op_head.oob) begin
						state_q <= ST_RUN;
						last_s1 <= last_first;
					end
				end
				ST_RUN: begin
					if (last_s1) begin
						state_q <= ST_IDLE;
					end else begin
						last_s1 <= last_nxt;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_push) begin
				owp_q <= !owp_q;
			end
			if (out_pop) begin
				orp_q <= !orp_q;
			end
			ocnt_q <= ocnt_q + 2'(out_push) - 2'(out_pop);
		end
	end

	assign empty   = (ocnt_q == 2'd0);
	assign out_pop = pop && !empty;
	assign result  = out_mem_q[orp_q].result;
	assign status  = out_mem_q[orp_q].status;

endmodule

### tb/vote_accumulator_patch_increment_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the vote accumulator core: directed and random requests.
module vote_accumulator_patch_increment_core_test;
	import vapi_pkg::*;

	localparam int GRID = 256;
	localparam bit [15:0] COUNT_TOP = 16'hFFFF;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic [1:0]       cmd = CMD_READ;
	logic [7:0]       row = '0;
	logic [7:0]       col = '0;
	logic [15:0]      value = '0;
	logic             pop = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_addr = REG_NUM_ROWS;
	logic [8:0]       cfg_wdata = '0;
	wire              full;
	wire              empty;
	wire  [RES_W-1:0] result;
	wire              status;

	// Shadow copy of the accumulator and its size registers.
	bit [15:0]   vote_counts [0:GRID*GRID-1];
	bit [8:0]    rows_setting = 9'd256;
	bit [8:0]    cols_setting = 9'd256;
	res_t        expected_votes [$];
	int unsigned mismatches = 0;
	bit          steady = 1'b0;
	int unsigned pop_stall = 0;

	vote_accumulator_patch_increment_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.row       (row),
		.col       (col),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int active_rows();
		return (rows_setting > GRID) ? GRID : int'(rows_setting);
	endfunction

	function automatic int active_cols();
		return (cols_setting > GRID) ? GRID : int'(cols_setting);
	endfunction

	function automatic bit [15:0] saturating_bump(input bit [15:0] count);
		return (count == COUNT_TOP) ? count : count + 16'd1;
	endfunction

	// Applies one request to the shadow store and returns the response it must produce.
	function automatic res_t predict_vote(input logic [1:0] op, input logic [7:0] r,
			input logic [7:0] c, input logic [15:0] data);
		res_t      outcome;
		int        nr;
		int        nc;
		int        rr;
		int        cc;
		int        slot_idx;
		bit [15:0] peak;
		nr = active_rows();
		nc = active_cols();
		outcome.result = '0;
		outcome.status = STATUS_OOB;
		if (int'(r) >= nr || int'(c) >= nc)
			return outcome;
		outcome.status = STATUS_OK;
		slot_idx = int'(r) * GRID + int'(c);
		case (op)
			CMD_WRITE: begin
				vote_counts[slot_idx] = data;
				outcome.result = data;
			end
			CMD_READ: begin
				outcome.result = vote_counts[slot_idx];
			end
			CMD_INC: begin
				vote_counts[slot_idx] = saturating_bump(vote_counts[slot_idx]);
				outcome.result = vote_counts[slot_idx];
			end
			default: begin
				peak = '0;
				for (rr = int'(r) - 1; rr <= int'(r) + 1; rr++)
					for (cc = int'(c) - 1; cc <= int'(c) + 1; cc++)
						if (rr >= 0 && cc >= 0 && rr < nr && cc < nc) begin
							if (vote_counts[rr*GRID + cc] > peak)
								peak = vote_counts[rr*GRID + cc];
							vote_counts[rr*GRID + cc] = saturating_bump(vote_counts[rr*GRID + cc]);
						end
				outcome.result = peak;
			end
		endcase
		return outcome;
	endfunction

	// Mostly no gap, some short ones, a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Coordinates cluster inside the active area and along its edges.
	function automatic logic [7:0] pick_coord(input int span);
		int unsigned roll;
		int          reach;
		roll = $urandom_range(0, 99);
		if (span == 0 || roll >= 85)
			return 8'($urandom_range(0, 255));
		reach = (span < 3) ? span - 1 : 2;
		if (roll < 40)
			return 8'($urandom_range(0, span - 1));
		if (roll < 55)
			return 8'($urandom_range(0, reach));
		if (roll < 70)
			return 8'(span - 1 - int'($urandom_range(0, reach)));
		return 8'(span + int'($urandom_range(0, 1)));
	endfunction

	function automatic logic [15:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			return 16'(COUNT_TOP - 16'($urandom_range(0, 3)));
		if (roll < 30)
			return 16'($urandom_range(0, 3));
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic logic [1:0] pick_cmd();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			return CMD_WRITE;
		if (roll < 40)
			return CMD_READ;
		if (roll < 65)
			return CMD_INC;
		return CMD_PATCH;
	endfunction

	// Presents one request and holds it until the core takes it.
	task automatic send_vote(input logic [1:0] op, input logic [7:0] r, input logic [7:0] c,
			input logic [15:0] data);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		cmd <= op;
		row <= r;
		col <= c;
		value <= data;
		do @(posedge clk); while (full);
		expected_votes.push_back(predict_vote(op, r, c, data));
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (full || expected_votes.size() != 0) @(posedge clk);
	endtask

	// Size registers change only once the core has gone quiet.
	task automatic set_size(input bit [8:0] rows_cfg, input bit [8:0] cols_cfg);
		wait_drained();
		repeat (16) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_NUM_ROWS;
		cfg_wdata <= rows_cfg;
		@(posedge clk);
		cfg_addr <= REG_NUM_COLS;
		cfg_wdata <= cols_cfg;
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_setting = rows_cfg;
		cols_setting = cols_cfg;
	endtask

	task automatic random_votes(input int count);
		repeat (count)
			send_vote(pick_cmd(), pick_coord(active_rows()), pick_coord(active_cols()),
				pick_value());
	endtask

	task automatic test_directed_cells();
		send_vote(CMD_WRITE, 8'd0, 8'd0, 16'hFFFF);
		send_vote(CMD_INC, 8'd0, 8'd0, 16'h0000);
		send_vote(CMD_READ, 8'd0, 8'd0, 16'h1234);
		send_vote(CMD_WRITE, 8'd255, 8'd255, 16'h0000);
		send_vote(CMD_INC, 8'd255, 8'd255, 16'hFFFF);
		send_vote(CMD_WRITE, 8'd0, 8'd255, 16'hA5A5);
		send_vote(CMD_WRITE, 8'd255, 8'd0, 16'h5A5A);
		send_vote(CMD_READ, 8'd255, 8'd0, 16'h0000);
		// A corner patch holds a saturated cell, which must stay saturated.
		send_vote(CMD_PATCH, 8'd0, 8'd0, 16'h0000);
		send_vote(CMD_PATCH, 8'd255, 8'd255, 16'h0000);
		send_vote(CMD_PATCH, 8'd128, 8'd127, 16'h0000);
		send_vote(CMD_READ, 8'd1, 8'd1, 16'h0000);
		send_vote(CMD_INC, 8'd129, 8'd128, 16'h0000);
	endtask

	task automatic test_directed_bounds();
		set_size(9'd10, 9'd20);
		send_vote(CMD_READ, 8'd9, 8'd19, 16'h0000);
		send_vote(CMD_INC, 8'd10, 8'd0, 16'h0000);
		send_vote(CMD_WRITE, 8'd0, 8'd20, 16'hFFFF);
		send_vote(CMD_PATCH, 8'd9, 8'd19, 16'h0000);
		send_vote(CMD_PATCH, 8'd255, 8'd255, 16'h0000);
		// With zero rows nothing is in range.
		set_size(9'd0, 9'd5);
		send_vote(CMD_WRITE, 8'd0, 8'd0, 16'h00FF);
		send_vote(CMD_PATCH, 8'd0, 8'd0, 16'h0000);
		set_size(9'd1, 9'd1);
		send_vote(CMD_PATCH, 8'd0, 8'd0, 16'h0000);
		send_vote(CMD_READ, 8'd0, 8'd1, 16'h0000);
		send_vote(CMD_READ, 8'd0, 8'd0, 16'h0000);
		// Sizes above the grid are clipped to it.
		set_size(9'd511, 9'd257);
		send_vote(CMD_PATCH, 8'd255, 8'd255, 16'h0000);
		send_vote(CMD_READ, 8'd255, 8'd254, 16'h0000);
	endtask

	task automatic test_small_grids();
		repeat (6) begin
			set_size(9'($urandom_range(1, 7)), 9'($urandom_range(1, 7)));
			random_votes(150);
		end
	endtask

	task automatic test_wide_grids();
		set_size(9'd511, 9'd256);
		random_votes(150);
		set_size(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
		random_votes(100);
	endtask

	task automatic test_drained_bursts();
		set_size(9'd4, 9'd4);
		steady = 1'b1;
		repeat (3) begin
			random_votes(20);
			wait_drained();
		end
		steady = 1'b0;
		random_votes(40);
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_votes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected response result=%0d status=%0d",
							$time, result, status);
				end else begin
					want = expected_votes.pop_front();
					if (result !== want.result || status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected result=%0d status=%0d, got result=%0d status=%0d",
								$time, want.result, want.status, result, status);
					end
				end
				pop_stall = pick_gap();
			end
			if (pop_stall > 0) begin
				pop <= 1'b0;
				pop_stall--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cells();
		test_directed_bounds();
		test_small_grids();
		test_wide_grids();
		test_drained_bursts();
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_votes.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#8ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
